// ----- hdl/pevd_pkg.sv -----
// Shared types and constants of the pointer event decoder.
`default_nettype none

package pevd_pkg;

  localparam logic [15:0] FUNC_KEY = 16'd1;
  localparam logic [15:0] FUNC_REL = 16'd2;
  localparam logic [15:0] FUNC_ABS = 16'd3;

  localparam logic [15:0] KEY_FIRST = 16'd1;
  localparam logic [15:0] KEY_LAST  = 16'd127;
  localparam logic [15:0] BTN_FIRST = 16'h0110;
  localparam logic [15:0] BTN_LAST  = 16'h011F;
  localparam logic [15:0] BTN_MASK  = 16'h000F;

  localparam logic [15:0] REL_X       = 16'd0;
  localparam logic [15:0] REL_Y       = 16'd1;
  localparam logic [15:0] REL_WHEEL_H = 16'd6;
  localparam logic [15:0] REL_WHEEL_V = 16'd8;

  localparam logic [15:0] ABS_X = 16'd0;
  localparam logic [15:0] ABS_Y = 16'd1;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [31:0] GAIN_RESET = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_ABS_MIN_X     = 3'd2,
    REG_ABS_MIN_Y     = 3'd3,
    REG_GAIN_X        = 3'd4,
    REG_GAIN_Y        = 3'd5,
    REG_CLICK_WINDOW  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    KIND_KEY_DOWN = 3'd0,
    KIND_KEY_UP   = 3'd1,
    KIND_BTN_DOWN = 3'd2,
    KIND_BTN_UP   = 3'd3,
    KIND_MOVE     = 3'd4,
    KIND_WHEEL    = 3'd5
  } kind_t;

  typedef struct packed {
    logic [15:0] func;
    logic [15:0] event_code;
    logic [31:0] event_value;
    logic [31:0] stamp;
    logic        abs_neg;
    logic [31:0] abs_mag;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  key_number;
    logic [4:0]  button_number;
    logic [15:0] pos_x_out;
    logic [15:0] pos_y_out;
    logic        dbl_click;
    logic        tpl_click;
    logic [31:0] wheel_amount;
    logic        wheel_horizontal;
  } out_word_t;

endpackage

`default_nettype wire

// ----- hdl/pevd_ifs.sv -----
// Channel interfaces of the pointer event decoder: event input, result output, register writes.
`default_nettype none

interface pevd_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] func;
  logic        [15:0] event_code;
  logic signed [31:0] event_value;
  logic        [31:0] stamp;

  modport source (output valid, func, event_code, event_value, stamp, input ready);
  modport sink   (input valid, func, event_code, event_value, stamp, output ready);
endinterface

interface pevd_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  kind;
  logic        [6:0]  key_number;
  logic        [4:0]  button_number;
  logic        [15:0] pos_x_out;
  logic        [15:0] pos_y_out;
  logic               dbl_click;
  logic               tpl_click;
  logic signed [31:0] wheel_amount;
  logic               wheel_horizontal;

  modport source (output valid, kind, key_number, button_number, pos_x_out, pos_y_out,
                  dbl_click, tpl_click, wheel_amount, wheel_horizontal,
                  input ready);
  modport sink   (input valid, kind, key_number, button_number, pos_x_out, pos_y_out,
                  dbl_click, tpl_click, wheel_amount, wheel_horizontal,
                  output ready);
endinterface

interface pevd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pevd_pkg::CFG_IDX_W-1:0] idx;
  logic [31:0]                    wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

`default_nettype wire

// ----- hdl/pointer_event_decoder_core.sv -----
// Pointer event decoder: top level, input register, decode and result register.
// Takes one event word per clock unless the output stalls and gives at most one
// result word for it; the event passes through the input register and then the
// result register before its result word is valid. The first stage registers
// the event together with the offset of an absolute reading from its minimum;
// the second holds the 32x32 gain multiplier, the clamps, the press time
// compares and the pointer state, and loads the result register. Events that
// decode to nothing leave no word. Register writes are taken every cycle.
`default_nettype none

module pointer_event_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  pevd_in_if.sink     in_if,
  pevd_out_if.source  out_if,
  pevd_cfg_if.sink    cfg_if
);

  logic [15:0] screen_width_r;
  logic [15:0] screen_height_r;
  logic [31:0] abs_min_x_r;
  logic [31:0] abs_min_y_r;
  logic [31:0] gain_x_r;
  logic [31:0] gain_y_r;
  logic [31:0] click_window_r;

  logic [15:0] pos_x_r, pos_x_nxt;
  logic [15:0] pos_y_r, pos_y_nxt;
  logic [31:0] prev_press_r, prev_press_nxt;
  logic [31:0] older_press_r, older_press_nxt;

  logic                s1_valid_r, s1_valid_nxt;
  pevd_pkg::in_word_t  s1_r, s1_nxt;
  logic                out_valid_r, out_valid_nxt;
  pevd_pkg::out_word_t out_r, res;
  logic                res_hit;

  logic out_load;
  logic s1_adv;
  logic in_acc;

  logic [31:0]        min_sel;
  logic signed [32:0] abs_d;

  logic [15:0]        lim;
  logic [15:0]        rel_base;
  logic signed [33:0] rel_sum;
  logic [15:0]        rel_pos;
  logic [31:0]        gain_sel;
  logic [63:0]        prod;
  logic [47:0]        scaled;
  logic [15:0]        abs_pos;
  logic [31:0]        e1;
  logic [31:0]        e2;
  logic               dbl;
  logic               tri_hit;
  logic [4:0]         btn;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= '0;
      screen_height_r <= '0;
      abs_min_x_r     <= '0;
      abs_min_y_r     <= '0;
      gain_x_r        <= pevd_pkg::GAIN_RESET;
      gain_y_r        <= pevd_pkg::GAIN_RESET;
      click_window_r  <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.idx)
        pevd_pkg::REG_SCREEN_WIDTH:  screen_width_r  <= cfg_if.wdata[15:0];
        pevd_pkg::REG_SCREEN_HEIGHT: screen_height_r <= cfg_if.wdata[15:0];
        pevd_pkg::REG_ABS_MIN_X:     abs_min_x_r     <= cfg_if.wdata;
        pevd_pkg::REG_ABS_MIN_Y:     abs_min_y_r     <= cfg_if.wdata;
        pevd_pkg::REG_GAIN_X:        gain_x_r        <= cfg_if.wdata;
        pevd_pkg::REG_GAIN_Y:        gain_y_r        <= cfg_if.wdata;
        pevd_pkg::REG_CLICK_WINDOW:  click_window_r  <= cfg_if.wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_load    = !out_valid_r || out_if.ready;
  assign s1_adv      = s1_valid_r && out_load;
  assign in_if.ready = !s1_valid_r || out_load;
  assign in_acc      = in_if.valid && in_if.ready;

  // offset of an absolute reading, exact in 33 bits
  always_comb begin
    min_sel = in_if.event_code[0] ? abs_min_y_r : abs_min_x_r;
    abs_d   = $signed({in_if.event_value[31], in_if.event_value})
            - $signed({min_sel[31], min_sel});
    s1_nxt.func        = in_if.func;
    s1_nxt.event_code  = in_if.event_code;
    s1_nxt.event_value = in_if.event_value;
    s1_nxt.stamp       = in_if.stamp;
    s1_nxt.abs_neg     = abs_d[32];
    s1_nxt.abs_mag     = abs_d[31:0];
  end

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // shared axis datapath
  always_comb begin
    lim      = s1_r.event_code[0] ? screen_height_r : screen_width_r;
    rel_base = s1_r.event_code[0] ? pos_y_r : pos_x_r;
    rel_sum  = $signed({18'd0, rel_base})
             + $signed({{2{s1_r.event_value[31]}}, s1_r.event_value});
    if (rel_sum[33]) begin
      rel_pos = '0;
    end else if (rel_sum[32:0] >= {17'd0, lim}) begin
      rel_pos = lim;
    end else begin
      rel_pos = rel_sum[15:0];
    end

    gain_sel = s1_r.event_code[0] ? gain_y_r : gain_x_r;
    prod     = {32'd0, s1_r.abs_mag} * {32'd0, gain_sel};
    scaled   = prod[63:16];
    if (s1_r.abs_neg) begin
      abs_pos = '0;
    end else if (scaled > {32'd0, lim}) begin
      abs_pos = lim;
    end else begin
      abs_pos = scaled[15:0];
    end

    e1      = s1_r.stamp - prev_press_r;
    e2      = s1_r.stamp - older_press_r;
    dbl     = e1 <= click_window_r;
    tri_hit = {1'b0, e2} <= {click_window_r, 1'b0};
    btn     = {1'b0, s1_r.event_code[3:0] & pevd_pkg::BTN_MASK[3:0]} + 5'd1;
  end

  always_comb begin
    res             = '0;
    res.pos_x_out   = pos_x_r;
    res.pos_y_out   = pos_y_r;
    res_hit         = 1'b0;
    pos_x_nxt       = pos_x_r;
    pos_y_nxt       = pos_y_r;
    prev_press_nxt  = prev_press_r;
    older_press_nxt = older_press_r;
    case (s1_r.func)
      pevd_pkg::FUNC_KEY: begin
        if (s1_r.event_code inside {[pevd_pkg::KEY_FIRST:pevd_pkg::KEY_LAST]}) begin
          res_hit        = 1'b1;
          res.kind       = (s1_r.event_value != '0) ? pevd_pkg::KIND_KEY_DOWN
                                                    : pevd_pkg::KIND_KEY_UP;
          res.key_number = s1_r.event_code[6:0];
          res.pos_x_out  = '0;
          res.pos_y_out  = '0;
        end else if (s1_r.event_code inside {[pevd_pkg::BTN_FIRST:pevd_pkg::BTN_LAST]}) begin
          res_hit           = 1'b1;
          res.button_number = btn;
          if (s1_r.event_value != '0) begin
            res.kind      = pevd_pkg::KIND_BTN_DOWN;
            res.dbl_click = dbl;
            res.tpl_click = tri_hit;
            if (tri_hit) begin
              prev_press_nxt  = '0;
              older_press_nxt = '0;
            end else begin
              older_press_nxt = prev_press_r;
              prev_press_nxt  = s1_r.stamp;
            end
          end else begin
            res.kind = pevd_pkg::KIND_BTN_UP;
          end
        end
      end
      pevd_pkg::FUNC_REL: begin
        case (s1_r.event_code)
          pevd_pkg::REL_X: begin
            res_hit       = 1'b1;
            res.kind      = pevd_pkg::KIND_MOVE;
            pos_x_nxt     = rel_pos;
            res.pos_x_out = rel_pos;
          end
          pevd_pkg::REL_Y: begin
            res_hit       = 1'b1;
            res.kind      = pevd_pkg::KIND_MOVE;
            pos_y_nxt     = rel_pos;
            res.pos_y_out = rel_pos;
          end
          pevd_pkg::REL_WHEEL_H, pevd_pkg::REL_WHEEL_V: begin
            res_hit              = 1'b1;
            res.kind             = pevd_pkg::KIND_WHEEL;
            res.wheel_amount     = s1_r.event_value;
            res.wheel_horizontal = (s1_r.event_code == pevd_pkg::REL_WHEEL_H);
          end
          default: begin
          end
        endcase
      end
      pevd_pkg::FUNC_ABS: begin
        if (s1_r.event_code == pevd_pkg::ABS_X || s1_r.event_code == pevd_pkg::ABS_Y) begin
          res_hit  = 1'b1;
          res.kind = pevd_pkg::KIND_MOVE;
          if (lim != '0) begin
            if (s1_r.event_code == pevd_pkg::ABS_X) begin
              pos_x_nxt     = abs_pos;
              res.pos_x_out = abs_pos;
            end else begin
              pos_y_nxt     = abs_pos;
              res.pos_y_out = abs_pos;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (!s1_adv) begin
      pos_x_nxt       = pos_x_r;
      pos_y_nxt       = pos_y_r;
      prev_press_nxt  = prev_press_r;
      older_press_nxt = older_press_r;
    end
  end

  assign out_valid_nxt = out_load ? (s1_valid_r && res_hit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      prev_press_r  <= '0;
      older_press_r <= '0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      pos_x_r       <= pos_x_nxt;
      pos_y_r       <= pos_y_nxt;
      prev_press_r  <= prev_press_nxt;
      older_press_r <= older_press_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.kind             = out_r.kind;
  assign out_if.key_number       = out_r.key_number;
  assign out_if.button_number    = out_r.button_number;
  assign out_if.pos_x_out        = out_r.pos_x_out;
  assign out_if.pos_y_out        = out_r.pos_y_out;
  assign out_if.dbl_click        = out_r.dbl_click;
  assign out_if.tpl_click        = out_r.tpl_click;
  assign out_if.wheel_amount     = out_r.wheel_amount;
  assign out_if.wheel_horizontal = out_r.wheel_horizontal;

endmodule

`default_nettype wire
